// ----- hw/rtl/clnf_pkg.sv -----
package clnf_pkg;

    // operation codes
    localparam logic [2:0] OP_CMD   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_DEC8  = 3'd2;
    localparam logic [2:0] OP_DEC16 = 3'd3;
    localparam logic [2:0] OP_HEX8  = 3'd4;
    localparam logic [2:0] OP_HEX16 = 3'd5;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // expander byte bits
    localparam logic [3:0] LOW_BACKLIGHT = 4'b1000;
    localparam logic [3:0] LOW_ENABLE    = 4'b0100;

    localparam logic [6:0] ADDR_RESET = 7'h27;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [7:0] expander_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAR,
        ST_CONV,
        ST_EMIT
    } fsm_state_t;

    // number of lcd characters per operation
    function automatic logic [2:0] char_count(input logic [2:0] op);
        logic [2:0] n;
        case (op)
            OP_DEC8:  n = 3'd4;
            OP_DEC16: n = 3'd6;
            OP_HEX8:  n = 3'd5;
            OP_HEX16: n = 3'd7;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    // true where the character is a decimal digit to be converted
    function automatic logic char_is_decimal(input logic [2:0] op, input logic [2:0] idx);
        logic d;
        case (op)
            OP_DEC8:  d = (idx < 3'd3);
            OP_DEC16: d = (idx < 3'd5);
            default:  d = 1'b0;
        endcase
        return d;
    endfunction

    // power of ten for a decimal digit position
    function automatic logic [13:0] dec_power(input logic [2:0] op, input logic [2:0] idx);
        logic [13:0] p;
        p = 14'd1;
        if (op == OP_DEC8) begin
            case (idx)
                3'd0:    p = 14'd100;
                3'd1:    p = 14'd10;
                default: p = 14'd1;
            endcase
        end else begin
            case (idx)
                3'd0:    p = 14'd10000;
                3'd1:    p = 14'd1000;
                3'd2:    p = 14'd100;
                3'd3:    p = 14'd10;
                default: p = 14'd1;
            endcase
        end
        return p;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = CHAR_ZERO + {4'd0, nib};
        else
            c = CHAR_UPPER + {4'd0, nib} - 8'd10;
        return c;
    endfunction

    // characters that need no conversion
    function automatic logic [7:0] fixed_char(input logic [2:0] op, input logic [2:0] idx,
                                              input logic [15:0] v);
        logic [7:0] c;
        c = CHAR_SPACE;
        case (op)
            OP_CMD, OP_DATA: c = v[7:0];
            OP_HEX8:
            begin
                case (idx)
                    3'd0:    c = CHAR_ZERO;
                    3'd1:    c = CHAR_X;
                    3'd2:    c = hex_char(v[7:4]);
                    3'd3:    c = hex_char(v[3:0]);
                    default: c = CHAR_SPACE;
                endcase
            end
            OP_HEX16:
            begin
                case (idx)
                    3'd0:    c = CHAR_ZERO;
                    3'd1:    c = CHAR_X;
                    3'd2:    c = hex_char(v[15:12]);
                    3'd3:    c = hex_char(v[11:8]);
                    3'd4:    c = hex_char(v[7:4]);
                    3'd5:    c = hex_char(v[3:0]);
                    default: c = CHAR_SPACE;
                endcase
            end
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/char_lcd_number_formatter_unit.sv -----
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------
// request   | start, busy             | req (operation, value)
// result    | strobe                  | result (bus_address, byte, last)
// config    | psel, penable, pwrite   | paddr, pwdata, prdata
//
// each lcd character passes a setup state, then for a decimal digit the
// shared compare/subtract unit subtracts the digit's power of ten until the
// remainder is below it, then 6 expander bytes are emitted. busy stays high
// from acceptance to the last byte.
// reset restores the device address to 0x27; results cannot be stalled.
module char_lcd_number_formatter_unit
    import clnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    req,
    output logic        strobe,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fsm_state_t  state_reg, state_next;
    logic [6:0]  addr_reg;
    logic [2:0]  op_reg, op_next;
    logic [15:0] value_reg, value_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  digit_reg, digit_next;
    logic [2:0]  idx_reg, idx_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  char_reg, char_next;

    logic [15:0] power;
    logic        ge;
    logic [3:0]  nib;
    logic        is_last;

    // config register
    assign pready = 1'b1;
    assign prdata = {25'd0, addr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= ADDR_RESET;
        else if (psel && penable && pwrite && !paddr[2])
            addr_reg <= pwdata[6:0];
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
            phase_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
        char_reg  <= char_next;
    end

    // shared compare/subtract unit
    assign power = {2'd0, dec_power(op_reg, idx_reg)};
    assign ge    = (rem_reg >= power);

    assign is_last = (phase_reg == 3'd5) && (idx_reg == char_count(op_reg) - 3'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        value_next = value_reg;
        rem_next   = rem_reg;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        char_next  = char_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (req.operation <= OP_HEX16))
                begin
                    op_next    = req.operation;
                    value_next = req.value;
                    if (req.operation inside {OP_DEC16, OP_HEX16})
                        rem_next = req.value;
                    else
                        rem_next = {8'd0, req.value[7:0]};
                    idx_next   = 3'd0;
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                digit_next = 4'd0;
                phase_next = 3'd0;
                if (char_is_decimal(op_reg, idx_reg))
                    state_next = ST_CONV;
                else
                begin
                    char_next  = fixed_char(op_reg, idx_reg, value_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_CONV:
            begin
                if (ge)
                begin
                    rem_next   = rem_reg - power;
                    digit_next = digit_reg + 4'd1;
                end
                else
                begin
                    char_next  = CHAR_ZERO | {4'd0, digit_reg};
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg == 3'd5)
                begin
                    if (is_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_CHAR;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output item
    assign nib    = (phase_reg < 3'd3) ? char_reg[7:4] : char_reg[3:0];
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);

    always_comb
    begin
        result.bus_address   = addr_reg;
        result.expander_byte = {nib, LOW_BACKLIGHT | {3'd0, (op_reg != OP_CMD)}};
        if (phase_reg == 3'd1 || phase_reg == 3'd4)
            result.expander_byte[3:0] = result.expander_byte[3:0] | LOW_ENABLE;
        result.last = is_last;
    end

endmodule

// ----- hw/rtl/clnf_checker.sv -----
module clnf_checker
    import clnf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      strobe,
    input out_item_t result
);

    // a result only appears while an item is in work
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while not busy");

    // no result in the cycle right after acceptance
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !strobe)
        else $error("result right after acceptance");

    // the last byte ends the item
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !busy)
        else $error("still busy after last byte");

    // the item continues until its last byte
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> busy)
        else $error("item ended without last byte");

    // backlight set and bit one clear on every byte
    a_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.expander_byte[3] && !result.expander_byte[1]))
        else $error("fixed expander bits wrong");

endmodule

bind char_lcd_number_formatter_unit clnf_checker u_clnf_checker (.*);
